[hw/rtl/dedeq_pkg.sv]
// Shared codes and types of the double-ended queue core.
package dedeq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP_FWD   = 3'd4;
  localparam logic [2:0] OP_DUMP_REV   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_DUMP = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic               at_front;   // front end, or forward order for a dump
    logic signed [31:0] value;
  } cmd_t;

endpackage

[hw/rtl/dedeq_front.sv]
// Front end: accepts transfers, decodes the operation and queues commands.
module dedeq_front
  import dedeq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       dec_ok;
  logic       enq;
  logic       deq;

  always_comb begin
    dec.value = value;
    dec.kind = KIND_PUSH;
    dec.at_front = 1'b0;
    dec_ok = 1'b1;
    unique case (operation) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        dec.kind = KIND_PUSH;
        dec.at_front = (operation == OP_PUSH_FRONT);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        dec.kind = KIND_POP;
        dec.at_front = (operation == OP_POP_FRONT);
      end
      OP_DUMP_FWD, OP_DUMP_REV: begin
        dec.kind = KIND_DUMP;
        dec.at_front = (operation == OP_DUMP_FWD);
      end
      default: dec_ok = 1'b0;  // unused codes are taken and dropped
    endcase
  end

  assign req_ready = (fill != 2'd2);
  assign enq       = req_valid && req_ready && dec_ok;
  assign cmd_valid = (fill != 2'd0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

[hw/rtl/dedeq_back.sv]
// Back end: ring store, head and count, command sequencer and result register.
module dedeq_back
  import dedeq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] value_res,
  output logic [1:0]         status,
  output logic               last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  logic [1:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;

  logic          wr_en, rd_en, load;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [31:0] load_value;
  logic [1:0]    load_status;
  logic          load_last;

  logic          free, full, empty;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] head_inc, head_dec, rd_idx, off_dump;
  logic [AW-1:0] slot_back, slot_back_m1, slot_dump;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    wrap = (s >= DEPTH_A) ? AW'(s - DEPTH_A) : s[AW-1:0];
  endfunction

  assign free     = !res_valid || res_ready;
  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign cnt_m1   = count - CW'(1);
  assign head_inc = (head == TOP_IDX) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? TOP_IDX : head - AW'(1);
  assign rd_idx   = (state == S_IDLE) ? '0 : idx;
  assign off_dump = cmd.at_front ? rd_idx : AW'(cnt_m1 - CW'(rd_idx));

  assign slot_back    = wrap({1'b0, head} + (AW + 1)'(count));
  assign slot_back_m1 = wrap({1'b0, head} + (AW + 1)'(cnt_m1));
  assign slot_dump    = wrap({1'b0, head} + {1'b0, off_dump});

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    idx_next    = idx;
    wr_en       = 1'b0;
    wr_addr     = slot_back;
    rd_en       = 1'b0;
    rd_addr     = head;
    load        = 1'b0;
    load_value  = '0;
    load_status = ST_OK;
    load_last   = 1'b1;
    cmd_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && free) begin
          unique case (cmd.kind)
            KIND_PUSH: begin
              load      = 1'b1;
              cmd_ready = 1'b1;
              if (full) begin
                load_status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = cmd.at_front ? head_dec : slot_back;
                head_next  = cmd.at_front ? head_dec : head;
                count_next = count + CW'(1);
              end
            end
            KIND_POP: begin
              if (empty) begin
                load        = 1'b1;
                load_status = ST_EMPTY;
                cmd_ready   = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = cmd.at_front ? head : slot_back_m1;
                head_next  = cmd.at_front ? head_inc : head;
                count_next = cnt_m1;
                state_next = S_RD;
              end
            end
            default: begin
              if (empty) begin
                load        = 1'b1;
                load_status = ST_EMPTY;
                cmd_ready   = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = slot_dump;
                idx_next   = '0;
                state_next = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        load       = 1'b1;
        load_value = rd_data;
        if (cmd.kind == KIND_DUMP && (CW'(idx) + CW'(1)) != count) begin
          load_last  = 1'b0;
          idx_next   = idx + AW'(1);
          state_next = S_WAIT;
        end else begin
          cmd_ready  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WAIT: begin
        if (free) begin
          rd_en      = 1'b1;
          rd_addr    = slot_dump;
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_res <= load_value;
      status    <= load_status;
      last      <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond capacity");

  a_read_before_load: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> $past(rd_en))
    else $error("result load without a preceding store read");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> !res_valid)
    else $error("store data arrived while result register occupied");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |-> value_res == '0 && last)
    else $error("error result carries data or no last mark");

endmodule

[hw/rtl/double_ended_queue_core.sv]
// Top level of the double-ended queue core.
// Double-ended queue of signed 32-bit values in a DEPTH-entry ring store.
// Requests are decoded and queued in a two-entry command queue, so the
// request side can take transfers while results wait, until that queue is
// full. Once a command reaches the back end, a push or a pop/dump of an
// empty queue yields its single result straight into the result register;
// a pop or a dump sends each stored value through the store's single
// registered read port before it reaches the result register. A push
// into a full queue is dropped with full status; codes six and seven are
// taken and produce no result. The store needs no clearing after reset.
module double_ended_queue_core
  import dedeq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] value_res,
  output logic [1:0]         status,
  output logic               last
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  dedeq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .operation (operation),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dedeq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .value_res (value_res),
    .status    (status),
    .last      (last)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the double-ended queue core.
`timescale 1ns / 100ps

module testbench
  import dedeq_pkg::*;
;

  localparam int DEPTH = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int RANDOM_ITEMS = 350;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int PH_SLOW_RES = 0;
  localparam int PH_SLOW_REQ = 1;
  localparam int PH_FREE     = 2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] val;
    int                 phase;
    logic               drain;
    logic               hold;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } deq_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [2:0]         operation = OP_PUSH_FRONT;
  logic signed [31:0] value = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic signed [31:0] value_res;
  logic [1:0]         status;
  logic               last;

  request_t    pending_requests[$];
  deq_result_t awaited_results[$];
  int          mismatch_count = 0;

  // own copy of the deque
  logic signed [31:0] dq_ring [DEPTH];
  int                 dq_head = 0;
  int                 dq_count = 0;

  int   cur_phase = PH_SLOW_RES;
  logic cur_hold = 1'b0;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;

  int   gen_phase = PH_SLOW_RES;
  logic gen_drain = 1'b0;
  logic gen_hold = 1'b0;

  double_ended_queue_core #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .operation (operation),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .value_res (value_res),
    .status    (status),
    .last      (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int send_idle_pct(input int ph);
    case (ph)
      PH_SLOW_RES: return 25;
      PH_SLOW_REQ: return 88;
      default:     return 0;
    endcase
  endfunction

  function automatic int res_stall_pct(input int ph);
    case (ph)
      PH_SLOW_RES: return 88;
      PH_SLOW_REQ: return 25;
      default:     return 0;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sh0;
      3:       return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  function automatic deq_result_t mk_result(input logic signed [31:0] v, input logic [1:0] st,
                                            input logic lst);
    deq_result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  task automatic add_req(input logic [2:0] op, input logic signed [31:0] val);
    request_t r;
    r.op    = op;
    r.val   = val;
    r.phase = gen_phase;
    r.drain = gen_drain;
    r.hold  = gen_hold;
    pending_requests.push_back(r);
    gen_drain = 1'b0;
    gen_hold  = 1'b0;
  endtask

  // expected results of one accepted transfer
  task automatic model_transfer(input logic [2:0] op, input logic signed [31:0] val);
    int off;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          awaited_results.push_back(mk_result('0, ST_FULL, 1'b1));
        end else begin
          if (op == OP_PUSH_FRONT) begin
            dq_head = (dq_head + DEPTH - 1) % DEPTH;
            dq_ring[dq_head] = val;
          end else begin
            dq_ring[(dq_head + dq_count) % DEPTH] = val;
          end
          dq_count++;
          awaited_results.push_back(mk_result('0, ST_OK, 1'b1));
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (dq_count == 0) begin
          awaited_results.push_back(mk_result('0, ST_EMPTY, 1'b1));
        end else if (op == OP_POP_FRONT) begin
          awaited_results.push_back(mk_result(dq_ring[dq_head], ST_OK, 1'b1));
          dq_head = (dq_head + 1) % DEPTH;
          dq_count--;
        end else begin
          awaited_results.push_back(mk_result(dq_ring[(dq_head + dq_count - 1) % DEPTH],
                                              ST_OK, 1'b1));
          dq_count--;
        end
      end
      OP_DUMP_FWD, OP_DUMP_REV: begin
        if (dq_count == 0) begin
          awaited_results.push_back(mk_result('0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < dq_count; i++) begin
            off = (op == OP_DUMP_FWD) ? i : dq_count - 1 - i;
            awaited_results.push_back(mk_result(dq_ring[(dq_head + off) % DEPTH], ST_OK,
                                                i + 1 == dq_count));
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : drive_requests
    request_t nxt;
    logic     busy;
    if (rst) begin
      req_valid <= 1'b0;
      hold_req  <= 1'b0;
    end else begin
      busy = req_valid;
      if (req_valid && req_ready) begin
        model_transfer(operation, value);
        busy = 1'b0;
      end
      hold_req <= req_valid && req_ready && cur_hold;
      if (!busy) begin
        if (pending_requests.size() > 0 &&
            !(pending_requests[0].drain && awaited_results.size() > 0) &&
            $urandom_range(99) >= send_idle_pct(pending_requests[0].phase)) begin
          nxt = pending_requests.pop_front();
          req_valid <= 1'b1;
          operation <= nxt.op;
          value     <= nxt.val;
          cur_hold  <= nxt.hold;
          cur_phase <= nxt.phase;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    deq_result_t exp_r;
    if (rst) begin
      res_ready <= 1'b0;
      hold_cnt  <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result value_res=%0d status=%0d last=%0b",
                   $time, value_res, status, last);
          mismatch_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (value_res !== exp_r.value || status !== exp_r.status || last !== exp_r.last) begin
            $display("%0t: mismatch expected value_res=%0d status=%0d last=%0b, got %0d %0d %0b",
                     $time, exp_r.value, exp_r.status, exp_r.last, value_res, status, last);
            mismatch_count++;
          end
        end
      end
      if (hold_req) begin
        hold_cnt  <= HOLD_CYCLES;
        res_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= $urandom_range(99) >= res_stall_pct(cur_phase);
      end
    end
  end

  initial begin : stimulus
    int n;
    int k;
    int new_phase;
    // empty cases, extremes, both ends, spare codes
    add_req(OP_POP_FRONT, 32'sh0);
    add_req(OP_POP_BACK, -32'sh1);
    add_req(OP_DUMP_FWD, 32'sh0);
    add_req(OP_DUMP_REV, 32'sh0);
    add_req(OP_PUSH_FRONT, 32'sh7fffffff);
    add_req(OP_PUSH_BACK, 32'sh80000000);
    add_req(OP_PUSH_FRONT, 32'sh0);
    add_req(OP_PUSH_BACK, -32'sh1);
    add_req(OP_DUMP_FWD, 32'sh0);
    add_req(OP_DUMP_REV, 32'sh0);
    add_req(OP_SPARE_6, 32'sh55555555);
    add_req(OP_SPARE_7, 32'shaaaaaaaa);
    add_req(OP_POP_FRONT, 32'sh0);
    add_req(OP_POP_BACK, 32'sh0);
    add_req(OP_DUMP_FWD, 32'sh0);
    add_req(OP_POP_BACK, 32'sh0);
    add_req(OP_POP_FRONT, 32'sh0);
    add_req(OP_POP_FRONT, 32'sh0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      new_phase = (n < RANDOM_ITEMS / 3) ? PH_SLOW_RES :
                  (n < 2 * RANDOM_ITEMS / 3) ? PH_SLOW_REQ : PH_FREE;
      if (new_phase != gen_phase) begin
        gen_phase = new_phase;
        gen_drain = 1'b1;
        gen_hold  = (new_phase == PH_FREE);
      end
      if (gen_phase == PH_SLOW_RES && n >= 40 && n < 60)
        gen_hold = 1'b1;
      if ($urandom_range(3) == 0) begin
        // fill past full, dump both ways, pop until past empty
        k = $urandom_range(DEPTH + 3, DEPTH + 1);
        repeat (k) add_req($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word());
        add_req(OP_DUMP_FWD, rand_word());
        add_req(OP_DUMP_REV, rand_word());
        repeat (DEPTH + 1) add_req($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, rand_word());
        n += k + DEPTH + 3;
      end else begin
        repeat (12) begin
          k = $urandom_range(99);
          if (k < 40) begin
            add_req($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word());
            n++;
          end else if (k < 75) begin
            add_req($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, rand_word());
            n++;
          end else if (k < 95) begin
            add_req($urandom_range(1) ? OP_DUMP_FWD : OP_DUMP_REV, rand_word());
            n++;
          end else begin
            add_req($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7, rand_word());
          end
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_requests.size() > 0 || req_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
